### src/cron_next_match_search_macros.svh
// ----------------------------------------------------------------------------
// cron next-match search: assertion macros
// shared property wrappers, clocked on the rising edge, held off in reset
// ----------------------------------------------------------------------------
`ifndef CRON_NEXT_MATCH_SEARCH_MACROS_SVH
`define CRON_NEXT_MATCH_SEARCH_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define CNMS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define CNMS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/cnms_pkg.sv
// ----------------------------------------------------------------------------
// cnms_pkg
// types, constants and calendar helpers of the cron next-match search
// ----------------------------------------------------------------------------
package cnms_pkg;

    // upper bound on candidates tested per query
    localparam int unsigned SEARCH_LIMIT = 527040;
    localparam int          STEP_W       = 20;

    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int WDAY_W    = 3;

    localparam int CFG_DATA_W  = 60;
    localparam int CFG_INDEX_W = 3;

    localparam logic [YEAR_W-1:0]   YEAR_MAX     = 14'd9998;
    localparam logic [MONTH_W-1:0]  MONTH_FIRST  = 4'd1;
    localparam logic [MONTH_W-1:0]  MONTH_FEB    = 4'd2;
    localparam logic [MONTH_W-1:0]  MONTH_APR    = 4'd4;
    localparam logic [MONTH_W-1:0]  MONTH_JUN    = 4'd6;
    localparam logic [MONTH_W-1:0]  MONTH_SEP    = 4'd9;
    localparam logic [MONTH_W-1:0]  MONTH_NOV    = 4'd11;
    localparam logic [MONTH_W-1:0]  MONTH_LAST   = 4'd12;
    localparam logic [DAY_W-1:0]    DAY_FIRST    = 5'd1;
    localparam logic [HOUR_W-1:0]   HOUR_LAST    = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_LAST  = 6'd59;
    localparam logic [WDAY_W-1:0]   WDAY_LAST    = 3'd6;

    // year kept modulo the 400-year Gregorian cycle for the leap rule
    localparam int                YMOD_W      = 9;
    localparam logic [YEAR_W-1:0] YEAR_CYCLE  = 14'd400;
    localparam logic [YMOD_W-1:0] YMOD_LAST   = 9'd399;
    localparam logic [YMOD_W-1:0] YMOD_C100   = 9'd100;
    localparam logic [YMOD_W-1:0] YMOD_C200   = 9'd200;
    localparam logic [YMOD_W-1:0] YMOD_C300   = 9'd300;
    // restoring reduction: subtract 400 << 4 down to 400 << 0
    localparam int DIV_STEPS  = 5;
    localparam int DIV_STEP_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MINUTE_MASK   = 3'd0,
        REG_HOUR_MASK     = 3'd1,
        REG_MONTHDAY_MASK = 3'd2,
        REG_MONTH_MASK    = 3'd3,
        REG_WEEKDAY_MASK  = 3'd4,
        REG_DAY_UNION     = 3'd5
    } cnms_reg_idx_t;

    typedef struct packed {
        logic [YEAR_W-1:0]   start_year;
        logic [MONTH_W-1:0]  start_month;
        logic [DAY_W-1:0]    start_day;
        logic [HOUR_W-1:0]   start_hour;
        logic [MINUTE_W-1:0] start_minute;
        logic [WDAY_W-1:0]   start_weekday;
    } cnms_in_t;

    typedef struct packed {
        logic                found;
        logic [YEAR_W-1:0]   match_year;
        logic [MONTH_W-1:0]  match_month;
        logic [DAY_W-1:0]    match_day;
        logic [HOUR_W-1:0]   match_hour;
        logic [MINUTE_W-1:0] match_minute;
        logic [WDAY_W-1:0]   match_weekday;
    } cnms_out_t;

    function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
        logic leap;
        if (ymod == '0) begin
            leap = 1'b1;
        end else if (ymod == YMOD_C100 || ymod == YMOD_C200 || ymod == YMOD_C300) begin
            leap = 1'b0;
        end else begin
            leap = (ymod[1:0] == 2'b00);
        end
        return leap;
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                    input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] days;
        case (month) inside
            MONTH_FEB: begin
                days = leap ? 5'd29 : 5'd28;
            end
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
                days = 5'd30;
            end
            default: begin
                days = 5'd31;
            end
        endcase
        return days;
    endfunction

endpackage

### src/cron_next_match_search.sv
// ----------------------------------------------------------------------------
// cron_next_match_search
// steps minute by minute from a start time to the first minute that hits the
// configured cron masks, with Gregorian month lengths, leap years and weekdays
// ----------------------------------------------------------------------------
//  channel   ports                        payload      direction
//  s_        s_valid / s_ready            cnms_in_t    start time in
//  m_        m_valid / m_ready            cnms_out_t   match result out
//  cfg_      cfg_wr_en / cfg_index        cfg_data     mask registers in
//
// after the input transfer, ST_YMOD reduces the year modulo 400 and ST_CLAMP clamps the
// day, then ST_SEARCH tests one candidate minute per cycle (at most SEARCH_LIMIT) and
// ST_FINISH loads the result: m_valid and s_ready rise together when it is loaded
// s_ready is low while a query runs; a finished result waits in the output
// register, so the next query may start meanwhile but cannot finish until it leaves
// aresetn is synchronous, active low; it restores all-ones masks, intersection
// ----------------------------------------------------------------------------
module cron_next_match_search import cnms_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  cnms_in_t               s_data,

    output logic                   m_valid,
    input  logic                   m_ready,
    output cnms_out_t              m_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YMOD,
        ST_CLAMP,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    // configuration
    logic [59:0] minute_mask_reg;
    logic [23:0] hour_mask_reg;
    logic [30:0] monthday_mask_reg;
    logic [11:0] month_mask_reg;
    logic [6:0]  weekday_mask_reg;
    logic        day_union_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            minute_mask_reg   <= '1;
            hour_mask_reg     <= '1;
            monthday_mask_reg <= '1;
            month_mask_reg    <= '1;
            weekday_mask_reg  <= '1;
            day_union_reg     <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MINUTE_MASK:   minute_mask_reg   <= cfg_data[59:0];
                REG_HOUR_MASK:     hour_mask_reg     <= cfg_data[23:0];
                REG_MONTHDAY_MASK: monthday_mask_reg <= cfg_data[30:0];
                REG_MONTH_MASK:    month_mask_reg    <= cfg_data[11:0];
                REG_WEEKDAY_MASK:  weekday_mask_reg  <= cfg_data[6:0];
                REG_DAY_UNION:     day_union_reg     <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    state_t                  state_reg, state_next;
    logic [YEAR_W-1:0]       year_reg, year_next;
    logic [MONTH_W-1:0]      month_reg, month_next;
    logic [DAY_W-1:0]        day_reg, day_next;
    logic [HOUR_W-1:0]       hour_reg, hour_next;
    logic [MINUTE_W-1:0]     minute_reg, minute_next;
    logic [WDAY_W-1:0]       wday_reg, wday_next;
    logic [YEAR_W-1:0]       ymod_reg, ymod_next;
    logic [DIV_STEP_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [STEP_W-1:0]       step_cnt_reg, step_cnt_next;
    logic                    found_reg, found_next;
    logic                    m_valid_reg, m_valid_next;
    cnms_out_t               m_data_reg, m_data_next;

    // calendar of the current candidate
    logic                    leap_cur;
    logic [DAY_W-1:0]        dim_cur;

    // advance unit: current candidate plus one minute
    logic [YEAR_W-1:0]       adv_year;
    logic [MONTH_W-1:0]      adv_month;
    logic [DAY_W-1:0]        adv_day;
    logic [HOUR_W-1:0]       adv_hour;
    logic [MINUTE_W-1:0]     adv_minute;
    logic [WDAY_W-1:0]       adv_wday;
    logic [YEAR_W-1:0]       adv_ymod;
    logic                    adv_match;
    logic                    dom_hit, dow_hit, day_ok;
    logic [DAY_W-1:0]        adv_day_idx;
    logic [MONTH_W-1:0]      adv_month_idx;

    // reduction step
    logic [DIV_STEP_W-1:0]   div_shamt;
    logic [YEAR_W-1:0]       div_sub;

    // input clamp
    logic [YEAR_W-1:0]       in_year;
    logic [MONTH_W-1:0]      in_month;
    logic [HOUR_W-1:0]       in_hour;
    logic [MINUTE_W-1:0]     in_minute;
    logic [WDAY_W-1:0]       in_wday;

    assign leap_cur = is_leap(ymod_reg[YMOD_W-1:0]);
    assign dim_cur  = month_days(leap_cur, month_reg);

    always_comb begin
        in_year   = (s_data.start_year > YEAR_MAX) ? YEAR_MAX : s_data.start_year;
        in_month  = s_data.start_month;
        if (in_month < MONTH_FIRST) begin
            in_month = MONTH_FIRST;
        end else if (in_month > MONTH_LAST) begin
            in_month = MONTH_LAST;
        end
        in_hour   = (s_data.start_hour > HOUR_LAST) ? HOUR_LAST : s_data.start_hour;
        in_minute = (s_data.start_minute > MINUTE_LAST) ? MINUTE_LAST
                                                        : s_data.start_minute;
        in_wday   = (s_data.start_weekday > WDAY_LAST) ? '0 : s_data.start_weekday;
    end

    always_comb begin
        adv_year   = year_reg;
        adv_month  = month_reg;
        adv_day    = day_reg;
        adv_hour   = hour_reg;
        adv_minute = minute_reg + 6'd1;
        adv_wday   = wday_reg;
        adv_ymod   = ymod_reg;
        if (minute_reg == MINUTE_LAST) begin
            adv_minute = '0;
            if (hour_reg == HOUR_LAST) begin
                adv_hour = '0;
                adv_wday = (wday_reg >= WDAY_LAST) ? '0 : wday_reg + 3'd1;
                if (day_reg >= dim_cur) begin
                    adv_day = DAY_FIRST;
                    if (month_reg == MONTH_LAST) begin
                        adv_month = MONTH_FIRST;
                        adv_year  = year_reg + 14'd1;
                        adv_ymod  = (ymod_reg[YMOD_W-1:0] == YMOD_LAST) ? '0
                                                                        : ymod_reg + 14'd1;
                    end else begin
                        adv_month = month_reg + 4'd1;
                    end
                end else begin
                    adv_day = day_reg + 5'd1;
                end
            end else begin
                adv_hour = hour_reg + 5'd1;
            end
        end
    end

    assign adv_day_idx   = adv_day - DAY_FIRST;
    assign adv_month_idx = adv_month - MONTH_FIRST;
    assign dom_hit   = monthday_mask_reg[adv_day_idx];
    assign dow_hit   = weekday_mask_reg[adv_wday];
    assign day_ok    = day_union_reg ? (dom_hit || dow_hit) : (dom_hit && dow_hit);
    assign adv_match = month_mask_reg[adv_month_idx] && day_ok
                    && hour_mask_reg[adv_hour] && minute_mask_reg[adv_minute];

    assign div_shamt = DIV_STEP_W'(DIV_STEPS - 1) - div_cnt_reg;
    assign div_sub   = YEAR_CYCLE << div_shamt;

    always_comb begin
        state_next    = state_reg;
        year_next     = year_reg;
        month_next    = month_reg;
        day_next      = day_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        wday_next     = wday_reg;
        ymod_next     = ymod_reg;
        div_cnt_next  = div_cnt_reg;
        step_cnt_next = step_cnt_reg;
        found_next    = found_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    year_next    = in_year;
                    month_next   = in_month;
                    day_next     = s_data.start_day;
                    hour_next    = in_hour;
                    minute_next  = in_minute;
                    wday_next    = in_wday;
                    ymod_next    = in_year;
                    div_cnt_next = '0;
                    state_next   = ST_YMOD;
                end
            end
            ST_YMOD: begin
                if (ymod_reg >= div_sub) begin
                    ymod_next = ymod_reg - div_sub;
                end
                div_cnt_next = div_cnt_reg + 3'd1;
                if (div_cnt_reg == DIV_STEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                if (day_reg < DAY_FIRST) begin
                    day_next = DAY_FIRST;
                end else if (day_reg > dim_cur) begin
                    day_next = dim_cur;
                end
                step_cnt_next = '0;
                state_next    = ST_SEARCH;
            end
            ST_SEARCH: begin
                year_next     = adv_year;
                month_next    = adv_month;
                day_next      = adv_day;
                hour_next     = adv_hour;
                minute_next   = adv_minute;
                wday_next     = adv_wday;
                ymod_next     = adv_ymod;
                step_cnt_next = step_cnt_reg + 20'd1;
                if (adv_match) begin
                    found_next = 1'b1;
                    state_next = ST_FINISH;
                end else if (step_cnt_next == STEP_W'(SEARCH_LIMIT)) begin
                    found_next = 1'b0;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // output register free or being emptied this cycle
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    if (found_reg) begin
                        m_data_next.found         = 1'b1;
                        m_data_next.match_year    = year_reg;
                        m_data_next.match_month   = month_reg;
                        m_data_next.match_day     = day_reg;
                        m_data_next.match_hour    = hour_reg;
                        m_data_next.match_minute  = minute_reg;
                        m_data_next.match_weekday = wday_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            found_reg    <= 1'b0;
            div_cnt_reg  <= '0;
            step_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            found_reg    <= found_next;
            div_cnt_reg  <= div_cnt_next;
            step_cnt_reg <= step_cnt_next;
        end
        year_reg   <= year_next;
        month_reg  <= month_next;
        day_reg    <= day_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        wday_reg   <= wday_next;
        ymod_reg   <= ymod_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### src/cnms_checker.sv
// ----------------------------------------------------------------------------
// cnms_checker
// port-level checks of the cron next-match search, bound to the top level
// ----------------------------------------------------------------------------
`include "cron_next_match_search_macros.svh"

module cnms_checker import cnms_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input cnms_out_t m_data
);

    // a stalled result holds
    `CNMS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // one query at a time: input closes right after a transfer
    `CNMS_ASSERT_NEXT(a_busy_after_take, aclk, aresetn, s_valid && s_ready, !s_ready, "input still open after transfer")

    // a miss carries an all-zero time
    `CNMS_ASSERT_SAME(a_miss_zero, aclk, aresetn, m_valid && !m_data.found, m_data == '0, "miss result not zero")

    // a hit has month, hour, minute and weekday in range and a day of at least 1
    `CNMS_ASSERT_SAME(a_hit_range, aclk, aresetn, m_valid && m_data.found, m_data.match_month >= 4'd1 && m_data.match_month <= 4'd12 && m_data.match_day >= 5'd1 && m_data.match_hour <= 5'd23 && m_data.match_minute <= 6'd59 && m_data.match_weekday <= 3'd6, "hit outside calendar range")

endmodule

bind cron_next_match_search cnms_checker u_cnms_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### verif/cron_next_match_search_tb.sv
// ----------------------------------------------------------------------------
// cron_next_match_search_tb
// drives start times into the next-match search under a series of mask
// settings, checks every match against its directed row or a minute-stepping
// calendar predictor; directed table first, then random queries
// ----------------------------------------------------------------------------
module cron_next_match_search_tb import cnms_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W           = $bits(cnms_in_t);
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 40;
    localparam int RAND_PHASES    = 5;
    localparam int RAND_PER_PHASE = 20;
    localparam int WATCHDOG_LIMIT = 4 * (int'(SEARCH_LIMIT) + 8) + 4 * HOLD_CYCLES;

    // register indexes past the end of the map, writes there are dropped
    localparam logic [CFG_INDEX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] IDX_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [59:0] minute;
        logic [23:0] hour;
        logic [30:0] mday;
        logic [11:0] month;
        logic [6:0]  wday;
        logic        day_or;
    } mask_set_t;

    typedef struct packed {
        mask_set_t masks;
        cnms_in_t  start;
        logic      typed;
        cnms_out_t want;
    } query_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    cnms_in_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    cnms_out_t              m_data;

    // predictor copy of the mask registers and of the walking candidate
    logic [59:0] allow_minute = '1;
    logic [23:0] allow_hour   = '1;
    logic [30:0] allow_mday   = '1;
    logic [11:0] allow_month  = '1;
    logic [6:0]  allow_wday   = '1;
    logic        union_mode   = 1'b0;
    int unsigned walk_year, walk_month, walk_day, walk_hour, walk_minute, walk_wday;
    int unsigned walk_steps;

    mask_set_t   current_masks;
    query_row_t  directed_rows[$];
    query_row_t  query_log[$];
    cnms_out_t   expected_matches[$];
    query_row_t  taken_row;
    cnms_out_t   want_out;

    bit quiet    = 1'b0;
    bit hold_req = 1'b0;
    int failures        = 0;
    int queries_taken   = 0;
    int results_checked = 0;
    int settings_loaded = 0;
    int idle_cycles     = 0;

    cron_next_match_search uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned days_in(input int unsigned y, input int unsigned m);
        bit leap;
        leap = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
        case (m)
            2: return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default: return 31;
        endcase
    endfunction

    function automatic cnms_out_t next_cron_match(input cnms_in_t q);
        cnms_out_t   res;
        bit          found;
        bit          dom, dow;
        int unsigned dim;
        res   = '0;
        found = 1'b0;
        // out-of-range start fields saturate before the walk; a weekday past 6 becomes 0
        walk_year   = (q.start_year > YEAR_MAX) ? YEAR_MAX : q.start_year;
        walk_month  = (q.start_month < 1) ? 1 : (q.start_month > 12) ? 12 : q.start_month;
        dim         = days_in(walk_year, walk_month);
        walk_day    = (q.start_day < 1) ? 1 : (q.start_day > dim) ? dim : q.start_day;
        walk_hour   = (q.start_hour > 23) ? 23 : q.start_hour;
        walk_minute = (q.start_minute > 59) ? 59 : q.start_minute;
        walk_wday   = (q.start_weekday > 6) ? 0 : q.start_weekday;
        walk_steps  = 0;
        while (!found && walk_steps < SEARCH_LIMIT) begin
            if (walk_minute != 59) begin
                walk_minute++;
            end else begin
                walk_minute = 0;
                if (walk_hour != 23) begin
                    walk_hour++;
                end else begin
                    walk_hour = 0;
                    walk_wday = (walk_wday >= 6) ? 0 : walk_wday + 1;
                    if (walk_day < days_in(walk_year, walk_month)) begin
                        walk_day++;
                    end else begin
                        walk_day = 1;
                        if (walk_month != 12) begin
                            walk_month++;
                        end else begin
                            walk_month = 1;
                            walk_year  = (walk_year + 1) & 32'h3FFF;
                        end
                    end
                end
            end
            walk_steps++;
            dom   = allow_mday[walk_day - 1];
            dow   = allow_wday[walk_wday];
            found = allow_month[walk_month - 1] && (union_mode ? (dom || dow) : (dom && dow))
                    && allow_hour[walk_hour] && allow_minute[walk_minute];
        end
        if (found) begin
            res.found         = 1'b1;
            res.match_year    = YEAR_W'(walk_year);
            res.match_month   = MONTH_W'(walk_month);
            res.match_day     = DAY_W'(walk_day);
            res.match_hour    = HOUR_W'(walk_hour);
            res.match_minute  = MINUTE_W'(walk_minute);
            res.match_weekday = WDAY_W'(walk_wday);
        end
        return res;
    endfunction

    function automatic mask_set_t masks(input logic [59:0] mi, input logic [23:0] h,
                                        input logic [30:0] md, input logic [11:0] mo,
                                        input logic [6:0] wd, input logic u);
        return {mi, h, md, mo, wd, u};
    endfunction

    function automatic cnms_in_t at(input int y, input int mo, input int d,
                                    input int h, input int mi, input int wd);
        return {YEAR_W'(y), MONTH_W'(mo), DAY_W'(d), HOUR_W'(h), MINUTE_W'(mi), WDAY_W'(wd)};
    endfunction

    function automatic cnms_out_t hit(input int y, input int mo, input int d,
                                      input int h, input int mi, input int wd);
        return {1'b1, YEAR_W'(y), MONTH_W'(mo), DAY_W'(d), HOUR_W'(h), MINUTE_W'(mi),
                WDAY_W'(wd)};
    endfunction

    function automatic void book(input mask_set_t ms, input cnms_in_t start,
                                 input logic typed, input cnms_out_t want);
        query_row_t row;
        row = {ms, start, typed, want};
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic logic [31:0] dense32();
        return $urandom | $urandom | $urandom;
    endfunction

    // mask in the low bits, random junk above the register width if asked
    function automatic logic [CFG_DATA_W-1:0] padded(input logic [CFG_DATA_W-1:0] bits,
                                                      input int w, input bit junk);
        logic [CFG_DATA_W-1:0] keep;
        keep = ({{(CFG_DATA_W-1){1'b0}}, 1'b1} << w) - 1'b1;
        return (bits & keep) | (junk ? (CFG_DATA_W'({$urandom, $urandom}) & ~keep) : '0);
    endfunction

    function automatic int field_bad(input string name, input int unsigned want,
                                     input int unsigned got);
        if (want == got) return 0;
        $error("%s: expected %0d, got %0d", name, want, got);
        return 1;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_MINUTE_MASK:   allow_minute = data[59:0];
            REG_HOUR_MASK:     allow_hour   = data[23:0];
            REG_MONTHDAY_MASK: allow_mday   = data[30:0];
            REG_MONTH_MASK:    allow_month  = data[11:0];
            REG_WEEKDAY_MASK:  allow_wday   = data[6:0];
            REG_DAY_UNION:     union_mode   = data[0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic load_masks(input mask_set_t ms, input bit junk);
        write_reg(REG_MINUTE_MASK,   padded(ms.minute, 60, junk));
        write_reg(REG_HOUR_MASK,     padded(ms.hour, 24, junk));
        write_reg(REG_MONTHDAY_MASK, padded(ms.mday, 31, junk));
        write_reg(REG_MONTH_MASK,    padded(ms.month, 12, junk));
        write_reg(REG_WEEKDAY_MASK,  padded(ms.wday, 7, junk));
        write_reg(REG_DAY_UNION,     padded(ms.day_or, 1, junk));
        write_reg($urandom_range(1) ? IDX_SPARE_HI : IDX_SPARE_LO,
                  CFG_DATA_W'({$urandom, $urandom}));
        cfg_wr_en <= 1'b0;
        current_masks = ms;
        settings_loaded++;
    endtask

    // entered and left at a falling edge
    task automatic offer(input query_row_t row);
        while (!quiet && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        query_log.insert(query_log.size(), row);
        s_valid <= 1'b1;
        s_data  <= row.start;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // wait for every outstanding match so the masks may change
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_matches.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_ready <= aresetn && (quiet || $urandom_range(99) >= 23);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            taken_row = query_log.pop_front();
            expected_matches.insert(expected_matches.size(),
                                    taken_row.typed ? taken_row.want
                                                    : next_cron_match(s_data));
            queries_taken++;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (expected_matches.size() == 0) begin
                $error("match result with no query outstanding: %p", m_data);
                failures++;
            end else begin
                want_out = expected_matches.pop_front();
                failures += field_bad("found", want_out.found, m_data.found)
                          + field_bad("match_year", want_out.match_year, m_data.match_year)
                          + field_bad("match_month", want_out.match_month, m_data.match_month)
                          + field_bad("match_day", want_out.match_day, m_data.match_day)
                          + field_bad("match_hour", want_out.match_hour, m_data.match_hour)
                          + field_bad("match_minute", want_out.match_minute,
                                      m_data.match_minute)
                          + field_bad("match_weekday", want_out.match_weekday,
                                      m_data.match_weekday);
            end
        end
    end

    // a not-found search is the longest quiet stretch the block may have
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        mask_set_t full_m, ms;
        cnms_in_t  q;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_data    = '0;

        full_m        = masks('1, '1, '1, '1, '1, 1'b0);
        current_masks = full_m;

        // reset masks: every query lands one minute after its start
        book(full_m, at(2023, 6, 15, 10, 30, 4), 1'b1, hit(2023, 6, 15, 10, 31, 4));
        book(full_m, at(2023, 6, 15, 10, 59, 4), 1'b1, hit(2023, 6, 15, 11, 0, 4));
        book(full_m, at(2023, 6, 30, 23, 59, 5), 1'b1, hit(2023, 7, 1, 0, 0, 6));
        book(full_m, at(2024, 2, 28, 23, 59, 3), 1'b1, hit(2024, 2, 29, 0, 0, 4));
        book(full_m, at(2023, 2, 28, 23, 59, 2), 1'b1, hit(2023, 3, 1, 0, 0, 3));
        book(full_m, at(2100, 2, 28, 23, 59, 0), 1'b1, hit(2100, 3, 1, 0, 0, 1));
        book(full_m, at(2000, 2, 28, 23, 59, 1), 1'b1, hit(2000, 2, 29, 0, 0, 2));
        book(full_m, at(9998, 12, 31, 23, 59, 6), 1'b1, hit(9999, 1, 1, 0, 0, 0));
        book(full_m, at(1970, 1, 1, 0, 0, 4), 1'b1, hit(1970, 1, 1, 0, 1, 4));
        // start fields past their range but the day, then fields at zero but the weekday
        book(full_m, at(16383, 15, 31, 31, 63, 7), 1'b1, hit(9999, 1, 1, 0, 0, 1));
        book(full_m, at(0, 0, 0, 0, 0, 3), 1'b1, hit(0, 1, 1, 0, 1, 3));
        // day beyond the month length clamps to its last day
        book(full_m, at(2023, 4, 31, 23, 59, 1), 1'b1, hit(2023, 5, 1, 0, 0, 2));
        book(full_m, at(2024, 2, 31, 23, 59, 4), 1'b1, hit(2024, 3, 1, 0, 0, 5));
        book(full_m, at(2023, 2, 30, 23, 59, 2), 1'b1, hit(2023, 3, 1, 0, 0, 3));
        book(masks(60'd1 << 59, 24'd1 << 23, '1, '1, '1, 1'b0),
             at(2023, 6, 15, 0, 0, 4), 1'b1, hit(2023, 6, 15, 23, 59, 4));
        book(masks(60'd1, 24'd1, '1, '1, '1, 1'b0),
             at(2023, 6, 15, 0, 0, 4), 1'b1, hit(2023, 6, 16, 0, 0, 5));
        book(masks('1, '1, 31'd1 << 30, 12'd1 << 11, '1, 1'b0),
             at(2023, 12, 30, 12, 0, 6), 1'b1, hit(2023, 12, 31, 0, 0, 0));
        book(masks('1, '1, 31'd1, '1, 7'd1, 1'b1), at(2023, 6, 15, 12, 0, 4), 1'b0, '0);
        book(masks('1, '1, 31'd1, '1, 7'd1, 1'b0), at(2023, 9, 20, 0, 0, 3), 1'b0, '0);
        book(masks('1, '1, '1, '1, 7'b1000000, 1'b0), at(2023, 6, 18, 5, 0, 0), 1'b0, '0);
        book(masks('1, '1, '0, '1, 7'b0001000, 1'b1), at(2023, 6, 15, 12, 0, 4), 1'b0, '0);
        // no month allowed: the whole search limit runs out
        book(masks('1, '1, '1, '0, '1, 1'b0), at(2023, 6, 15, 12, 0, 4), 1'b1, '0);
        // skips the first of january 9999 on weekday and lands past 9999
        book(masks(60'd1, 24'd1, 31'd1, 12'd1, 7'b0000100, 1'b0),
             at(9998, 12, 31, 23, 59, 0), 1'b1, hit(10000, 1, 1, 0, 0, 2));

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].masks != current_masks) begin
                settle();
                load_masks(directed_rows[i].masks, 1'b0);
            end
            offer(directed_rows[i]);
        end

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            // dense masks keep the searches short
            ms.minute = 60'({dense32(), dense32()});
            ms.hour   = 24'(dense32());
            ms.mday   = 31'(dense32());
            ms.month  = 12'(dense32());
            ms.wday   = 7'(dense32());
            ms.day_or = 1'($urandom_range(1));
            settle();
            load_masks(ms, 1'b1);
            quiet = (phase == 2);
            if (phase == 1) hold_req = 1'b1;
            repeat (RAND_PER_PHASE) begin
                q.start_year    = YEAR_W'($urandom_range(9998, 1970));
                q.start_month   = MONTH_W'($urandom_range(12, 1));
                q.start_day     = DAY_W'($urandom_range(days_in(q.start_year,
                                                                q.start_month), 1));
                q.start_hour    = HOUR_W'($urandom_range(23));
                q.start_minute  = MINUTE_W'($urandom_range(59));
                q.start_weekday = WDAY_W'($urandom_range(6));
                if ($urandom_range(3) == 0) begin
                    q.start_hour   = HOUR_LAST;
                    q.start_minute = MINUTE_W'($urandom_range(59, 50));
                end
                if ($urandom_range(9) == 0) q.start_year = YEAR_W'($urandom_range(9998, 9990));
                if ($urandom_range(4) == 0) q = IN_W'({$urandom, $urandom});
                offer({ms, q, 1'b0, cnms_out_t'('0)});
            end
        end
        quiet = 1'b0;

        settle();
        repeat (TAIL_CYCLES) @(negedge aclk);
        failures += expected_matches.size();

        $display("covered %0d directed and %0d random queries over %0d mask settings",
                 directed_rows.size(), RAND_PHASES * RAND_PER_PHASE, settings_loaded);
        $display("%0d queries taken, %0d matches checked, %0d failures",
                 queries_taken, results_checked, failures);
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### cron_next_match_search.f
+incdir+src
src/cnms_pkg.sv
src/cron_next_match_search.sv
src/cnms_checker.sv
verif/cron_next_match_search_tb.sv
